FILE: design/i9dtu_pkg.sv
// ----------------------------------------------------------------------------
// i9dtu_pkg
// Shared types and constants for the ISO 9660 date to Unix time converter.
// ----------------------------------------------------------------------------
package i9dtu_pkg;

  localparam int YEAR_W  = 19;  // calendar year, ASCII digits may go negative
  localparam int PART_W  = 13;  // month, day, hour, minute, second
  localparam int TZ_W    = 7;   // zone offset after the window check
  localparam int DIGIT_W = 9;   // ASCII byte minus '0'
  localparam int OUT_W   = 41;

  localparam int BASE_YEAR  = 1900;
  localparam int EPOCH_YEAR = 1970;
  localparam int TZ_LIMIT   = 52;
  localparam int ASCII_ZERO = 48;

  typedef enum logic {
    CMD_BINARY = 1'b0,
    CMD_ASCII  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic signed [PART_W-1:0] month;
    logic signed [PART_W-1:0] day;
    logic signed [PART_W-1:0] hour;
    logic signed [PART_W-1:0] minute;
    logic signed [PART_W-1:0] second;
    logic signed [TZ_W-1:0]   tz;
  } date_t;

  // Days before the first of month m, indexed by m-1; last entry is a full year.
  localparam logic [8:0] MONTH_CUM [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // Months below one add nothing, months above twelve add a whole year.
  function automatic logic [8:0] month_base(input logic signed [PART_W-1:0] month);
    logic [3:0] idx;
    if (month <= 1) begin
      idx = 4'd0;
    end else if (month >= 13) begin
      idx = 4'd12;
    end else begin
      idx = 4'(month - 1);
    end
    return MONTH_CUM[idx];
  endfunction

endpackage

FILE: design/i9dtu_decode.sv
// ----------------------------------------------------------------------------
// i9dtu_decode
// Pulls the date fields out of either the binary record or the ASCII
// descriptor text, and applies the zone window and the zone override.
// ----------------------------------------------------------------------------
module i9dtu_decode (
  input  logic                  cmd_i,
  input  logic [63:0]           date_chars_i,
  input  logic [47:0]           clock_chars_i,
  input  logic [7:0]            year_since_1900_i,
  input  logic [7:0]            month_num_i,
  input  logic [7:0]            day_num_i,
  input  logic [7:0]            hour_num_i,
  input  logic [7:0]            minute_num_i,
  input  logic [7:0]            second_num_i,
  input  logic signed [7:0]     zone_offset_i,
  input  logic                  ignore_tz_i,
  output i9dtu_pkg::date_t      date_o
);

  localparam int DW = i9dtu_pkg::DIGIT_W;
  localparam int PW = i9dtu_pkg::PART_W;
  localparam int YW = i9dtu_pkg::YEAR_W;

  // Non-digit characters are used as is: value lies in -48..207.
  function automatic logic signed [DW-1:0] digit(input logic [7:0] b);
    return $signed({1'b0, b}) - DW'(i9dtu_pkg::ASCII_ZERO);
  endfunction

  function automatic logic signed [PW-1:0] pair(input logic [7:0] hi, input logic [7:0] lo);
    logic signed [PW-1:0] h;
    logic signed [PW-1:0] l;
    h = PW'(digit(hi));
    l = PW'(digit(lo));
    return h * $signed(PW'(10)) + l;
  endfunction

  logic signed [YW-1:0] asc_year;
  logic signed [7:0]    tz_lim;
  logic                 tz_use;

  always_comb begin
    asc_year = YW'(digit(date_chars_i[63:56])) * $signed(YW'(1000))
             + YW'(digit(date_chars_i[55:48])) * $signed(YW'(100))
             + YW'(digit(date_chars_i[47:40])) * $signed(YW'(10))
             + YW'(digit(date_chars_i[39:32]));
  end

  assign tz_lim = 8'(i9dtu_pkg::TZ_LIMIT);
  assign tz_use = !ignore_tz_i && (zone_offset_i >= -tz_lim) && (zone_offset_i <= tz_lim);

  always_comb begin
    unique case (i9dtu_pkg::cmd_e'(cmd_i))
      i9dtu_pkg::CMD_BINARY: begin
        date_o.year   = $signed(YW'(i9dtu_pkg::BASE_YEAR)) + $signed(YW'(year_since_1900_i));
        date_o.month  = $signed(PW'(month_num_i));
        date_o.day    = $signed(PW'(day_num_i));
        date_o.hour   = $signed(PW'(hour_num_i));
        date_o.minute = $signed(PW'(minute_num_i));
        date_o.second = $signed(PW'(second_num_i));
      end
      i9dtu_pkg::CMD_ASCII: begin
        date_o.year   = asc_year;
        date_o.month  = pair(date_chars_i[31:24], date_chars_i[23:16]);
        date_o.day    = pair(date_chars_i[15:8], date_chars_i[7:0]);
        date_o.hour   = pair(clock_chars_i[47:40], clock_chars_i[39:32]);
        date_o.minute = pair(clock_chars_i[31:24], clock_chars_i[23:16]);
        date_o.second = pair(clock_chars_i[15:8], clock_chars_i[7:0]);
      end
    endcase
    date_o.tz = tz_use ? i9dtu_pkg::TZ_W'(zone_offset_i) : '0;
  end

endmodule

FILE: design/iso9660_date_to_unix_time.sv
// ----------------------------------------------------------------------------
// iso9660_date_to_unix_time
// Throughput: one conversion per cycle unless the output stalls; seven register
// stages: decode, day of year, day count, x24, x60, x60 with zone, clamp.
// Reset: pipeline valid bits and ignore_timezone clear; data regs are not reset.
// Converts one ISO 9660 binary or ASCII timestamp to signed Unix seconds.
// ----------------------------------------------------------------------------
module iso9660_date_to_unix_time (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic [63:0]              date_chars_i,
  input  logic [47:0]              clock_chars_i,
  input  logic [7:0]               year_since_1900_i,
  input  logic [7:0]               month_num_i,
  input  logic [7:0]               day_num_i,
  input  logic [7:0]               hour_num_i,
  input  logic [7:0]               minute_num_i,
  input  logic [7:0]               second_num_i,
  input  logic signed [7:0]        zone_offset_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [40:0]       unix_time_o
);

  localparam int PW    = i9dtu_pkg::PART_W;
  localparam int YW    = i9dtu_pkg::YEAR_W;
  localparam int OW    = i9dtu_pkg::OUT_W;
  localparam int Y_W   = 18;  // years since 1970, non-negative
  localparam int TZS_W = 17;  // zone offset in seconds
  localparam int DAY_W = 28;
  localparam int HR_W  = 32;
  localparam int MN_W  = 38;
  localparam int SC_W  = 44;
  localparam int NSTG  = 7;

  localparam logic signed [SC_W-1:0] OUT_MAX = SC_W'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [SC_W-1:0] OUT_MIN = -SC_W'(64'sd1 <<< (OW - 1));

  // ---------------------------------------------------------------- config
  logic ignore_tz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_tz_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ignore_tz_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [NSTG:1] v_q, v_d, en, v_in;

  // A stage loads when it is empty or the stage after it loads.
  always_comb begin
    en[NSTG] = !v_q[NSTG] || out_ready_i;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in = {v_q[NSTG-1:1], in_valid_i};
  assign v_d  = (en & v_in) | (~en & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NSTG];

  // ---------------------------------------------------------------- stage 1: decode
  i9dtu_pkg::date_t dec, s1_q;

  i9dtu_decode u_decode (
    .cmd_i             (cmd_i),
    .date_chars_i      (date_chars_i),
    .clock_chars_i     (clock_chars_i),
    .year_since_1900_i (year_since_1900_i),
    .month_num_i       (month_num_i),
    .day_num_i         (day_num_i),
    .hour_num_i        (hour_num_i),
    .minute_num_i      (minute_num_i),
    .second_num_i      (second_num_i),
    .zone_offset_i     (zone_offset_i),
    .ignore_tz_i       (ignore_tz_q),
    .date_o            (dec)
  );

  always_ff @(posedge clk_i) begin
    if (en[1]) s1_q <= dec;
  end

  // ---------------------------------------------------------------- stage 2: year offset, day of year
  logic signed [YW-1:0]    yr_off;
  logic                    leap_d;
  logic [8:0]              mbase;
  logic [Y_W-1:0]          s2_y_q;
  logic                    s2_neg_q;
  logic signed [PW-1:0]    s2_dpart_q, s2_dpart_d;
  logic signed [PW-1:0]    s2_hour_q, s2_min_q, s2_sec_q;
  logic signed [TZS_W-1:0] s2_tzs_q, s2_tzs_d;

  always_comb begin
    yr_off     = s1_q.year - $signed(YW'(i9dtu_pkg::EPOCH_YEAR));
    // (y+2) divisible by four, past February
    leap_d     = (yr_off[1:0] == 2'd2) && (s1_q.month > 2);
    mbase      = i9dtu_pkg::month_base(s1_q.month);
    s2_dpart_d = $signed(PW'(mbase)) + $signed(PW'(leap_d)) + s1_q.day - $signed(PW'(1));
    s2_tzs_d   = $signed(TZS_W'(s1_q.tz)) * $signed(TZS_W'(900));
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_y_q     <= yr_off[Y_W-1:0];
      s2_neg_q   <= yr_off[YW-1];
      s2_dpart_q <= s2_dpart_d;
      s2_hour_q  <= s1_q.hour;
      s2_min_q   <= s1_q.minute;
      s2_sec_q   <= s1_q.second;
      s2_tzs_q   <= s2_tzs_d;
    end
  end

  // ---------------------------------------------------------------- stage 3: day count
  logic [Y_W-1:0]          leap_cnt;
  logic signed [DAY_W-1:0] s3_days_q, s3_days_d;
  logic                    s3_neg_q;
  logic signed [PW-1:0]    s3_hour_q, s3_min_q, s3_sec_q;
  logic signed [TZS_W-1:0] s3_tzs_q;

  always_comb begin
    leap_cnt  = (s2_y_q > Y_W'(2)) ? ((s2_y_q + Y_W'(1)) >> 2) : '0;
    s3_days_d = $signed(DAY_W'(s2_y_q)) * $signed(DAY_W'(365))
              + $signed(DAY_W'(leap_cnt)) + DAY_W'(s2_dpart_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_days_q <= s3_days_d;
      s3_neg_q  <= s2_neg_q;
      s3_hour_q <= s2_hour_q;
      s3_min_q  <= s2_min_q;
      s3_sec_q  <= s2_sec_q;
      s3_tzs_q  <= s2_tzs_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: hours
  logic signed [HR_W-1:0]  s4_hr_q;
  logic                    s4_neg_q;
  logic signed [PW-1:0]    s4_min_q, s4_sec_q;
  logic signed [TZS_W-1:0] s4_tzs_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_hr_q  <= HR_W'(s3_days_q) * $signed(HR_W'(24)) + HR_W'(s3_hour_q);
      s4_neg_q <= s3_neg_q;
      s4_min_q <= s3_min_q;
      s4_sec_q <= s3_sec_q;
      s4_tzs_q <= s3_tzs_q;
    end
  end

  // ---------------------------------------------------------------- stage 5: minutes
  logic signed [MN_W-1:0]  s5_mn_q;
  logic                    s5_neg_q;
  logic signed [PW-1:0]    s5_sec_q;
  logic signed [TZS_W-1:0] s5_tzs_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_mn_q  <= MN_W'(s4_hr_q) * $signed(MN_W'(60)) + MN_W'(s4_min_q);
      s5_neg_q <= s4_neg_q;
      s5_sec_q <= s4_sec_q;
      s5_tzs_q <= s4_tzs_q;
    end
  end

  // ---------------------------------------------------------------- stage 6: seconds, zone
  logic signed [SC_W-1:0] s6_sc_q;
  logic                   s6_neg_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_sc_q  <= SC_W'(s5_mn_q) * $signed(SC_W'(60)) + SC_W'(s5_sec_q) - SC_W'(s5_tzs_q);
      s6_neg_q <= s5_neg_q;
    end
  end

  // ---------------------------------------------------------------- stage 7: clamp
  logic signed [OW-1:0] res_d, res_q;

  always_comb begin
    priority if (s6_neg_q) begin
      res_d = '0;  // pre-1970 dates
    end else if (s6_sc_q > OUT_MAX) begin
      res_d = OUT_MAX[OW-1:0];
    end else if (s6_sc_q < OUT_MIN) begin
      res_d = OUT_MIN[OW-1:0];
    end else begin
      res_d = s6_sc_q[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) res_q <= res_d;
  end

  assign unix_time_o = res_q;

`ifndef SYNTH
  // Items in flight change only by transfers at the two ends.
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(v_q) == $past($countones(v_q))
                        + int'($past(in_valid_i && in_ready_o))
                        - int'($past(out_valid_o && out_ready_i))))
    else $error("pipeline occupancy mismatch");

  // An empty output stage never backpressures the input.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output stage");

  // Under output stall the input only waits when every stage is full.
  a_bubble_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_ready_i |-> (in_ready_o == !(&v_q)))
    else $error("bubble not collapsed under output stall");
`endif

endmodule
